### rtl/gb3_pkg.sv
// Shared types, register codes and reset values for the 3x3 Gaussian blur stream block.
package gb3_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 1024;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int RESULT_DEPTH       = 16;

    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 16;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [IMG_W_W-1:0]  WIDTH_RST         = 11'd640;
    localparam logic [IMG_H_W-1:0]  HEIGHT_RST        = 16'd480;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CENTER_RST = 16'd13076;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SIDE_RST   = 16'd8026;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CORNER_RST = 16'd4926;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_WEIGHT_CENTER = 3'd2,
        REG_WEIGHT_SIDE   = 3'd3,
        REG_WEIGHT_CORNER = 3'd4
    } reg_idx_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } action_t;

    typedef logic [PIX_W-1:0] pix_t;

    // window[row][col]: row 0 oldest line, col 2 newest column
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] center;
        logic [WEIGHT_W-1:0] side;
        logic [WEIGHT_W-1:0] corner;
    } weights_t;

    // per-request result tag carried alongside the filter pipeline
    typedef struct packed {
        logic two;
        logic blur;
        pix_t pass0;
        pix_t pass1;
    } res_tag_t;

    // one queue entry: all results caused by one request
    typedef struct packed {
        logic two;
        pix_t pix0;
        pix_t pix1;
    } res_pair_t;

endpackage

### rtl/gb3_kernel.sv
// Three-stage weighted-sum pipeline: neighbor sums, weight products, add/shift/saturate.
module gb3_kernel #(
    parameter int FRAC_BITS = gb3_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  gb3_pkg::res_tag_t   in_tag,
    input  gb3_pkg::win_t       in_win,
    input  gb3_pkg::weights_t   weights,
    output logic                out_valid,
    output gb3_pkg::res_pair_t  out_pair
);

    localparam int SUM4_W = gb3_pkg::PIX_W + 2;
    localparam int PROD_W = gb3_pkg::WEIGHT_W + SUM4_W;
    localparam int ACC_W  = PROD_W + 2;

    // stage A: neighbor sums
    logic              a_valid_reg;
    gb3_pkg::res_tag_t a_tag_reg;
    logic [SUM4_W-1:0] a_sides_reg, a_sides_next;
    logic [SUM4_W-1:0] a_corners_reg, a_corners_next;
    gb3_pkg::pix_t     a_center_reg;

    // stage B: products
    logic              b_valid_reg;
    gb3_pkg::res_tag_t b_tag_reg;
    logic [PROD_W-1:0] b_pc_reg, b_pc_next;
    logic [PROD_W-1:0] b_ps_reg, b_ps_next;
    logic [PROD_W-1:0] b_pk_reg, b_pk_next;

    // stage C: result
    logic               c_valid_reg;
    gb3_pkg::res_pair_t c_pair_reg, c_pair_next;
    logic [ACC_W-1:0]   acc, shifted;
    gb3_pkg::pix_t      sat;

    always_comb begin
        a_sides_next = SUM4_W'(in_win[0][1]) + SUM4_W'(in_win[2][1])
                     + SUM4_W'(in_win[1][0]) + SUM4_W'(in_win[1][2]);
        a_corners_next = SUM4_W'(in_win[0][0]) + SUM4_W'(in_win[0][2])
                       + SUM4_W'(in_win[2][0]) + SUM4_W'(in_win[2][2]);
    end

    always_comb begin
        b_pc_next = PROD_W'(weights.center) * PROD_W'(a_center_reg);
        b_ps_next = PROD_W'(weights.side)   * PROD_W'(a_sides_reg);
        b_pk_next = PROD_W'(weights.corner) * PROD_W'(a_corners_reg);
    end

    always_comb begin
        acc     = ACC_W'(b_pc_reg) + ACC_W'(b_ps_reg) + ACC_W'(b_pk_reg);
        shifted = acc >> FRAC_BITS;
        if (shifted > ACC_W'(gb3_pkg::PIX_MAX)) begin
            sat = gb3_pkg::PIX_MAX;
        end else begin
            sat = shifted[gb3_pkg::PIX_W-1:0];
        end
        c_pair_next.two  = b_tag_reg.two;
        c_pair_next.pix0 = b_tag_reg.blur ? sat : b_tag_reg.pass0;
        c_pair_next.pix1 = b_tag_reg.pass1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_tag_reg     <= in_tag;
        a_sides_reg   <= a_sides_next;
        a_corners_reg <= a_corners_next;
        a_center_reg  <= in_win[1][1];
        b_tag_reg     <= a_tag_reg;
        b_pc_reg      <= b_pc_next;
        b_ps_reg      <= b_ps_next;
        b_pk_reg      <= b_pk_next;
        c_pair_reg    <= c_pair_next;
    end

    assign out_valid = c_valid_reg;
    assign out_pair  = c_pair_reg;

endmodule

### rtl/gb3_res_fifo.sv
// Result queue with slot reservation; serializes one or two results per entry.
module gb3_res_fifo #(
    parameter int DEPTH = gb3_pkg::RESULT_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                reserve,
    output logic                has_room,
    input  logic                wr_valid,
    input  gb3_pkg::res_pair_t  wr_pair,
    output logic                out_valid,
    input  logic                out_ready,
    output gb3_pkg::pix_t       out_data,
    output logic                out_last
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gb3_pkg::res_pair_t ent_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] credit_reg, credit_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             sub_reg, sub_next;
    logic             pop;
    gb3_pkg::res_pair_t head;

    assign head      = ent_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign out_data  = sub_reg ? head.pix1 : head.pix0;
    assign out_last  = !head.two || sub_reg;
    assign pop       = out_valid && out_ready && out_last;
    assign has_room  = (credit_reg < CNT_W'(DEPTH));

    always_comb begin
        credit_next = credit_reg + CNT_W'(reserve) - CNT_W'(pop);
        count_next  = count_reg + CNT_W'(wr_valid) - CNT_W'(pop);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        if (wr_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_valid && out_ready) begin
            sub_next = !out_last;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            credit_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            credit_reg <= credit_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            ent_reg[wr_ptr_reg] <= wr_pair;
        end
    end

endmodule

### rtl/gaussian_blur_3x3_stream.sv
// Top level of the streaming 3x3 Gaussian blur: control, line memory, window and ports.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+----------------------------------------
//   s_       | in        | s_tvalid / s_tready | s_tdata = pixel_in, s_tuser = action
//   m_       | out       | m_tvalid / m_tready | m_tdata = pixel_out, m_tlast = last_of_run
//   APB      | in        | psel/penable/pready | regs at 4*i: width, height, w_c, w_s, w_k
//
// One request is taken per clock while s_tready is high. A request that ends a row (or a
// drain request) yields its results as one queue entry; an end-of-row pixel has two.
// A request passes memory read, window, three filter stages and the queue. s_tready falls
// only when all RESULT_DEPTH queue slots are reserved by requests in flight or results not
// yet taken. aresetn is synchronous; it clears counters and pipeline valids, loads reset
// values into the config registers; the line memory is not cleared and needs no sweep.
module gaussian_blur_3x3_stream #(
    parameter int MAX_LINE_WIDTH       = gb3_pkg::MAX_LINE_WIDTH_DEF,
    parameter int WEIGHT_FRACTION_BITS = gb3_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_in
    input  logic [0:0]                        s_tuser,   // [0] action
    // stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gb3_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [gb3_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int ADDR_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int CNT_W  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int EXT_W  = (CNT_W > gb3_pkg::IMG_W_W) ? CNT_W : gb3_pkg::IMG_W_W;
    localparam int PIX_W  = gb3_pkg::PIX_W;
    localparam int H_W    = gb3_pkg::IMG_H_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gb3_pkg::IMG_W_W-1:0] width_reg;
    logic [H_W-1:0]              height_reg;
    gb3_pkg::weights_t           weights_reg;
    gb3_pkg::reg_idx_t           cfg_idx;
    logic                        cfg_wr;
    logic                        geo_restart;

    assign pready  = 1'b1;
    assign cfg_idx = gb3_pkg::reg_idx_t'(paddr[gb3_pkg::CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign geo_restart = cfg_wr && (cfg_idx == gb3_pkg::REG_IMAGE_WIDTH ||
                                    cfg_idx == gb3_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg          <= gb3_pkg::WIDTH_RST;
            height_reg         <= gb3_pkg::HEIGHT_RST;
            weights_reg.center <= gb3_pkg::WEIGHT_CENTER_RST;
            weights_reg.side   <= gb3_pkg::WEIGHT_SIDE_RST;
            weights_reg.corner <= gb3_pkg::WEIGHT_CORNER_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                gb3_pkg::REG_IMAGE_WIDTH:   width_reg <= pwdata[gb3_pkg::IMG_W_W-1:0];
                gb3_pkg::REG_IMAGE_HEIGHT:  height_reg <= pwdata[H_W-1:0];
                gb3_pkg::REG_WEIGHT_CENTER: weights_reg.center <= pwdata[gb3_pkg::WEIGHT_W-1:0];
                gb3_pkg::REG_WEIGHT_SIDE:   weights_reg.side <= pwdata[gb3_pkg::WEIGHT_W-1:0];
                gb3_pkg::REG_WEIGHT_CORNER: weights_reg.corner <= pwdata[gb3_pkg::WEIGHT_W-1:0];
                default: ;  // drop writes to unused addresses
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            gb3_pkg::REG_IMAGE_WIDTH:   prdata = gb3_pkg::CFG_DATA_W'(width_reg);
            gb3_pkg::REG_IMAGE_HEIGHT:  prdata = gb3_pkg::CFG_DATA_W'(height_reg);
            gb3_pkg::REG_WEIGHT_CENTER: prdata = gb3_pkg::CFG_DATA_W'(weights_reg.center);
            gb3_pkg::REG_WEIGHT_SIDE:   prdata = gb3_pkg::CFG_DATA_W'(weights_reg.side);
            gb3_pkg::REG_WEIGHT_CORNER: prdata = gb3_pkg::CFG_DATA_W'(weights_reg.corner);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective geometry: width clamped to 3..MAX_LINE_WIDTH, height at least 3
    // ------------------------------------------------------------------
    logic [EXT_W-1:0] width_ext;
    logic [CNT_W-1:0] eff_w;
    logic [H_W-1:0]   eff_h;

    always_comb begin
        width_ext = EXT_W'(width_reg);
        if (width_ext < EXT_W'(3)) begin
            eff_w = CNT_W'(3);
        end else if (width_ext > EXT_W'(MAX_LINE_WIDTH)) begin
            eff_w = CNT_W'(MAX_LINE_WIDTH);
        end else begin
            eff_w = CNT_W'(width_ext);
        end
        eff_h = (height_reg < H_W'(3)) ? H_W'(3) : height_reg;
    end

    // ------------------------------------------------------------------
    // Request stage: counters, emission decisions, memory read issue
    // ------------------------------------------------------------------
    logic [H_W-1:0]   row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] drain_reg, drain_next;

    logic             s_acc;
    logic             is_drain;
    logic             drain_ok;
    logic             wrap;
    logic [H_W-1:0]   cur_r;
    logic [CNT_W-1:0] cur_c;
    logic [CNT_W-1:0] col_inc;
    logic [CNT_W-1:0] drain_inc;
    logic             emit_px;
    logic             two_px;
    logic             blur_px;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic             reserve;
    logic             has_room;

    assign s_tready = has_room;
    assign s_acc    = s_tvalid && s_tready;
    assign is_drain = (gb3_pkg::action_t'(s_tuser[0]) == gb3_pkg::ACT_DRAIN);
    assign drain_ok = (row_reg >= eff_h) && (drain_reg < eff_w);

    always_comb begin
        wrap      = (row_reg >= eff_h) || (col_reg >= eff_w);
        cur_r     = wrap ? '0 : row_reg;
        cur_c     = wrap ? '0 : col_reg;
        col_inc   = cur_c + 1'b1;
        drain_inc = drain_reg + 1'b1;
        emit_px   = (cur_r != '0) && (cur_c != '0);
        two_px    = emit_px && (cur_c == eff_w - 1'b1);
        blur_px   = (cur_r != H_W'(1)) && (cur_c != CNT_W'(1));
        rd_en     = s_acc && (!is_drain || drain_ok);
        rd_addr   = is_drain ? drain_reg[ADDR_W-1:0] : cur_c[ADDR_W-1:0];
        reserve   = s_acc && (is_drain ? drain_ok : emit_px);
    end

    always_comb begin
        row_next   = row_reg;
        col_next   = col_reg;
        drain_next = drain_reg;
        if (geo_restart) begin
            row_next   = '0;
            col_next   = '0;
            drain_next = '0;
        end else if (s_acc) begin
            if (is_drain) begin
                if (drain_ok) begin
                    // last drain of the row returns the frame to its start
                    if (drain_inc >= eff_w) begin
                        row_next   = '0;
                        col_next   = '0;
                        drain_next = '0;
                    end else begin
                        drain_next = drain_inc;
                    end
                end
            end else begin
                drain_next = wrap ? '0 : drain_reg;
                if (col_inc >= eff_w) begin
                    col_next = '0;
                    row_next = cur_r + 1'b1;
                end else begin
                    col_next = col_inc;
                    row_next = cur_r;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= '0;
        end else begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
        end
    end

    // ------------------------------------------------------------------
    // Memory stage: line memory read-modify-write and window shift
    // ------------------------------------------------------------------
    // entry layout: [15:8] row r-2 (older), [7:0] row r-1 (newer)
    logic [2*PIX_W-1:0] line_mem [MAX_LINE_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic [2*PIX_W-1:0] line_word;
    logic [2*PIX_W-1:0] wr_data;
    logic               mem_wr;

    logic              s1_valid_reg;
    logic              s1_drain_reg;
    logic              s1_emit_reg;
    logic              s1_two_reg;
    logic              s1_blur_reg;
    gb3_pkg::pix_t     s1_px_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    gb3_pkg::win_t     win_reg;
    logic              k_valid_reg;
    gb3_pkg::res_tag_t k_tag_reg, k_tag_next;

    assign line_word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign mem_wr    = s1_valid_reg && !s1_drain_reg;
    assign wr_data   = {line_word[PIX_W-1:0], s1_px_reg};

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            line_mem[s1_addr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    // bypass a write that lands on the entry being read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            k_valid_reg  <= 1'b0;
        end else begin
            fwd_hit_reg  <= rd_en && mem_wr && (rd_addr == s1_addr_reg);
            s1_valid_reg <= rd_en;
            k_valid_reg  <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr_data;
        if (rd_en) begin
            s1_drain_reg <= is_drain;
            s1_emit_reg  <= is_drain ? drain_ok : emit_px;
            s1_two_reg   <= !is_drain && two_px;
            s1_blur_reg  <= !is_drain && blur_px;
            s1_px_reg    <= s_tdata;
            s1_addr_reg  <= rd_addr;
        end
    end

    // Drain results come straight from the newer line; pixel pass-through takes the
    // column that moves into the window center, plus the newest column at row end.
    always_comb begin
        k_tag_next.two   = s1_two_reg;
        k_tag_next.blur  = s1_blur_reg;
        k_tag_next.pass0 = s1_drain_reg ? line_word[PIX_W-1:0] : win_reg[1][2];
        k_tag_next.pass1 = line_word[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        k_tag_reg <= k_tag_next;
        if (mem_wr) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= line_word[2*PIX_W-1:PIX_W];
            win_reg[1][2] <= line_word[PIX_W-1:0];
            win_reg[2][2] <= s1_px_reg;
        end
    end

    // ------------------------------------------------------------------
    // Filter pipeline and result queue
    // ------------------------------------------------------------------
    logic               res_valid;
    gb3_pkg::res_pair_t res_pair;

    gb3_kernel #(
        .FRAC_BITS (WEIGHT_FRACTION_BITS)
    ) u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (k_valid_reg),
        .in_tag    (k_tag_reg),
        .in_win    (win_reg),
        .weights   (weights_reg),
        .out_valid (res_valid),
        .out_pair  (res_pair)
    );

    gb3_res_fifo #(
        .DEPTH (gb3_pkg::RESULT_DEPTH)
    ) u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .reserve   (reserve),
        .has_room  (has_room),
        .wr_valid  (res_valid),
        .wr_pair   (res_pair),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/gb3_checker.sv
// Port-level checks for the blur stream block, bound to the top level.
module gb3_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [7:0]                     m_tdata,
    input logic                           m_tlast,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic                           pready,
    input logic [gb3_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [gb3_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [gb3_pkg::CFG_DATA_W-1:0] prdata
);

    // reset empties the result queue and frees every slot
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("queue not empty or input stalled after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // the second result of a request is stored with the first, so it follows at once
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("second result of a request not ready");

    // weight registers read back what was written
    a_weight_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready &&
         (paddr[gb3_pkg::CFG_ADDR_W-1:2] == gb3_pkg::REG_WEIGHT_CENTER ||
          paddr[gb3_pkg::CFG_ADDR_W-1:2] == gb3_pkg::REG_WEIGHT_SIDE ||
          paddr[gb3_pkg::CFG_ADDR_W-1:2] == gb3_pkg::REG_WEIGHT_CORNER))
        ##1 (psel && !pwrite && paddr == $past(paddr))
        |-> (prdata == gb3_pkg::CFG_DATA_W'($past(pwdata[gb3_pkg::WEIGHT_W-1:0]))))
        else $error("weight register read-back mismatch");

endmodule

bind gaussian_blur_3x3_stream gb3_checker u_gb3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
